// ===== hw/rtl/ssvf_pkg.sv =====
package ssvf_pkg;

    typedef enum logic [1:0] {
        KIND_MIN_SEC  = 2'd0,
        KIND_HOUR_MIN = 2'd1,
        KIND_VOLTAGE  = 2'd2,
        KIND_TEMP     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        D3_DIGIT = 2'd0,
        D3_DASH  = 2'd1,
        D3_BLANK = 2'd2
    } d3_mode_t;

    typedef logic [3:0] digit_t;
    typedef logic [6:0] seg_t;

    localparam int unsigned WORD_W = 15;

    localparam seg_t SEG_BLANK = 7'h00;
    localparam seg_t SEG_DASH  = 7'h40;

    localparam logic [11:0] ADC_ZERO     = 12'd2692;
    localparam logic [12:0] TEMP_MUL     = 13'd4225;
    localparam logic [11:0] TEMP_DIV     = 12'd4095;
    localparam logic [24:0] TEMP_DIV_M   = 25'd16781313;
    localparam logic [9:0]  DAY_DIV      = 10'd675;
    localparam logic [22:0] DAY_DIV_M    = 23'd6362914;
    localparam logic [15:0] DIV15_M      = 16'd34953;
    localparam logic [12:0] DIV225_M     = 13'd4661;
    localparam logic [15:0] DIV10_M      = 16'd52429;
    localparam logic [12:0] DIV100_M     = 13'd5243;
    localparam logic [12:0] DIV1000_M    = 13'd4195;
    localparam logic [7:0]  DIV10_SMALL_M = 8'd205;

    function automatic seg_t seg_of(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/ssvf_seg_pack.sv =====
module ssvf_seg_pack
    import ssvf_pkg::*;
(
    input  digit_t [3:0]        digits,
    input  d3_mode_t            d3_mode,
    output logic [WORD_W-1:0]   upper_word,
    output logic [WORD_W-1:0]   lower_word
);

    seg_t seg3;

    always_comb
    begin
        unique case (d3_mode)
            D3_DIGIT: seg3 = seg_of(digits[3]);
            D3_DASH:  seg3 = SEG_DASH;
            D3_BLANK: seg3 = SEG_BLANK;
            default:  seg3 = SEG_BLANK;
        endcase
    end

    assign upper_word = {seg3, 1'b0, seg_of(digits[2])};
    assign lower_word = {seg_of(digits[1]), 1'b0, seg_of(digits[0])};

endmodule

// ===== hw/rtl/seven_segment_view_formatter_unit.sv =====
// Formats one view per transaction into seven-segment patterns for four digits: minutes and
// seconds or hours and minutes of the time of day, a 12-bit voltage sample, or a temperature
// converted from a 12-bit ADC sample with a leading dash when negative. The six-stage pipeline
// takes one transaction every cycle while it is not full and carries each result through the
// stage registers one to six to the output; item_ready drops only when all six stages hold
// results and result_ready is low. Results leave in the order the items arrived.
module seven_segment_view_formatter_unit
    import ssvf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          kind,
    input  logic [31:0]         value,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [WORD_W-1:0]   upper_digits_word,
    output logic [WORD_W-1:0]   lower_digits_word
);

    logic en1, en2, en3, en4, en5, en6;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;

    assign en6 = !s6_valid_reg || result_ready;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign item_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= item_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
        end
    end

    // stage 1: day quotient estimate, temperature product
    kind_t        s1_kind_reg;
    logic [6:0]   s1_low7_reg;
    logic [24:0]  s1_n_reg;
    logic [15:0]  s1_qe_reg, s1_qe_next;
    logic         s1_neg_reg, s1_neg_next;
    logic [23:0]  s1_p_reg, s1_p_next;
    logic [11:0]  s1_x_reg;
    logic [47:0]  day_prod;
    logic [11:0]  adc_abs;

    always_comb
    begin
        day_prod    = {23'd0, value[31:7]} * {25'd0, DAY_DIV_M};
        s1_qe_next  = day_prod[47:32];
        s1_neg_next = value[11:0] < ADC_ZERO;
        adc_abs     = s1_neg_next ? (ADC_ZERO - value[11:0]) : (value[11:0] - ADC_ZERO);
        s1_p_next   = {12'd0, adc_abs} * {11'd0, TEMP_MUL};
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_kind_reg <= kind_t'(kind);
            s1_low7_reg <= value[6:0];
            s1_n_reg    <= value[31:7];
            s1_qe_reg   <= s1_qe_next;
            s1_neg_reg  <= s1_neg_next;
            s1_p_reg    <= s1_p_next;
            s1_x_reg    <= value[11:0];
        end
    end

    // stage 2: day remainder before correction, temperature quotient estimate
    kind_t        s2_kind_reg;
    logic [6:0]   s2_low7_reg;
    logic [10:0]  s2_r0_reg, s2_r0_next;
    logic [11:0]  s2_q2e_reg, s2_q2e_next;
    logic         s2_neg_reg;
    logic [23:0]  s2_p_reg;
    logic [11:0]  s2_x_reg;
    logic [24:0]  day_back;
    logic [24:0]  day_diff;
    logic [48:0]  temp_prod;

    always_comb
    begin
        day_back    = {9'd0, s1_qe_reg} * {15'd0, DAY_DIV};
        day_diff    = s1_n_reg - day_back;
        s2_r0_next  = day_diff[10:0];
        temp_prod   = {25'd0, s1_p_reg} * {24'd0, TEMP_DIV_M};
        s2_q2e_next = temp_prod[47:36];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_low7_reg <= s1_low7_reg;
            s2_r0_reg   <= s2_r0_next;
            s2_q2e_reg  <= s2_q2e_next;
            s2_neg_reg  <= s1_neg_reg;
            s2_p_reg    <= s1_p_reg;
            s2_x_reg    <= s1_x_reg;
        end
    end

    // stage 3: correct day remainder and temperature quotient, form time of day and BCD source
    kind_t        s3_kind_reg;
    logic [16:0]  s3_t_reg, s3_t_next;
    logic [11:0]  s3_v_reg, s3_v_next;
    logic         s3_neg_reg;
    logic [10:0]  day_r;
    logic [23:0]  temp_back;
    logic [23:0]  temp_rem;
    logic [11:0]  temp_mag;

    always_comb
    begin
        day_r     = (s2_r0_reg >= {1'b0, DAY_DIV}) ? (s2_r0_reg - {1'b0, DAY_DIV}) : s2_r0_reg;
        s3_t_next = {day_r[9:0], s2_low7_reg};
        temp_back = {12'd0, s2_q2e_reg} * {12'd0, TEMP_DIV};
        temp_rem  = s2_p_reg - temp_back;
        temp_mag  = (temp_rem >= {12'd0, TEMP_DIV}) ? (s2_q2e_reg + 12'd1) : s2_q2e_reg;
        s3_v_next = (s2_kind_reg == KIND_TEMP) ? temp_mag : s2_x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_t_reg    <= s3_t_next;
            s3_v_reg    <= s3_v_next;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // stage 4: total minutes and hours, decimal quotients of the sample
    kind_t        s4_kind_reg;
    logic [16:0]  s4_t_reg;
    logic [10:0]  s4_a_reg, s4_a_next;
    logic [4:0]   s4_h_reg, s4_h_next;
    logic [11:0]  s4_v_reg;
    logic [8:0]   s4_q10_reg, s4_q10_next;
    logic [5:0]   s4_q100_reg, s4_q100_next;
    logic [2:0]   s4_q1000_reg, s4_q1000_next;
    logic         s4_neg_reg;
    logic [30:0]  min_prod;
    logic [25:0]  hour_prod;
    logic [27:0]  q10_prod;
    logic [24:0]  q100_prod;
    logic [24:0]  q1000_prod;

    always_comb
    begin
        min_prod      = {16'd0, s3_t_reg[16:2]} * {15'd0, DIV15_M};
        s4_a_next     = min_prod[29:19];
        hour_prod     = {13'd0, s3_t_reg[16:4]} * {13'd0, DIV225_M};
        s4_h_next     = hour_prod[24:20];
        q10_prod      = {16'd0, s3_v_reg} * {12'd0, DIV10_M};
        s4_q10_next   = q10_prod[27:19];
        q100_prod     = {13'd0, s3_v_reg} * {12'd0, DIV100_M};
        s4_q100_next  = q100_prod[24:19];
        q1000_prod    = {13'd0, s3_v_reg} * {12'd0, DIV1000_M};
        s4_q1000_next = q1000_prod[24:22];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_t_reg     <= s3_t_reg;
            s4_a_reg     <= s4_a_next;
            s4_h_reg     <= s4_h_next;
            s4_v_reg     <= s3_v_reg;
            s4_q10_reg   <= s4_q10_next;
            s4_q100_reg  <= s4_q100_next;
            s4_q1000_reg <= s4_q1000_next;
            s4_neg_reg   <= s3_neg_reg;
        end
    end

    // stage 5: seconds and minutes, select the two time fields, sample digits
    kind_t          s5_kind_reg;
    logic [5:0]     s5_lo_reg, s5_lo_next;
    logic [5:0]     s5_hi_reg, s5_hi_next;
    digit_t [3:0]   s5_dig_reg, s5_dig_next;
    logic           s5_neg_reg;
    logic [16:0]    sec_full;
    logic [10:0]    mnt_full;
    logic [11:0]    d0_full;
    logic [8:0]     d1_full;
    logic [5:0]     d2_full;

    always_comb
    begin
        sec_full       = s4_t_reg - ({6'd0, s4_a_reg} * 17'd60);
        mnt_full       = s4_a_reg - ({6'd0, s4_h_reg} * 11'd60);
        s5_lo_next     = (s4_kind_reg == KIND_MIN_SEC) ? sec_full[5:0] : mnt_full[5:0];
        s5_hi_next     = (s4_kind_reg == KIND_MIN_SEC) ? mnt_full[5:0] : {1'b0, s4_h_reg};
        d0_full        = s4_v_reg - ({3'd0, s4_q10_reg} * 12'd10);
        d1_full        = s4_q10_reg - ({3'd0, s4_q100_reg} * 9'd10);
        d2_full        = s4_q100_reg - ({3'd0, s4_q1000_reg} * 6'd10);
        s5_dig_next[0] = d0_full[3:0];
        s5_dig_next[1] = d1_full[3:0];
        s5_dig_next[2] = d2_full[3:0];
        s5_dig_next[3] = {1'b0, s4_q1000_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_kind_reg <= s4_kind_reg;
            s5_lo_reg   <= s5_lo_next;
            s5_hi_reg   <= s5_hi_next;
            s5_dig_reg  <= s5_dig_next;
            s5_neg_reg  <= s4_neg_reg;
        end
    end

    // stage 6: split time fields into digits, encode segments
    logic [13:0]        lo_prod, hi_prod;
    logic [2:0]         lo_tens, hi_tens;
    logic [5:0]         lo_units, hi_units;
    digit_t [3:0]       digits;
    d3_mode_t           d3_mode;
    logic [WORD_W-1:0]  upper_next, lower_next;
    logic [WORD_W-1:0]  upper_digits_word_reg, lower_digits_word_reg;

    always_comb
    begin
        lo_prod  = {8'd0, s5_lo_reg} * {6'd0, DIV10_SMALL_M};
        lo_tens  = lo_prod[13:11];
        lo_units = s5_lo_reg - ({3'd0, lo_tens} * 6'd10);
        hi_prod  = {8'd0, s5_hi_reg} * {6'd0, DIV10_SMALL_M};
        hi_tens  = hi_prod[13:11];
        hi_units = s5_hi_reg - ({3'd0, hi_tens} * 6'd10);
        case (s5_kind_reg) inside
            KIND_MIN_SEC, KIND_HOUR_MIN:
            begin
                digits[0] = lo_units[3:0];
                digits[1] = {1'b0, lo_tens};
                digits[2] = hi_units[3:0];
                digits[3] = {1'b0, hi_tens};
                d3_mode   = D3_DIGIT;
            end
            KIND_VOLTAGE:
            begin
                digits  = s5_dig_reg;
                d3_mode = D3_DIGIT;
            end
            default:
            begin
                digits  = s5_dig_reg;
                d3_mode = s5_neg_reg ? D3_DASH : D3_BLANK;
            end
        endcase
    end

    ssvf_seg_pack u_seg_pack (
        .digits     (digits),
        .d3_mode    (d3_mode),
        .upper_word (upper_next),
        .lower_word (lower_next)
    );

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            upper_digits_word_reg <= upper_next;
            lower_digits_word_reg <= lower_next;
        end
    end

    assign result_valid      = s6_valid_reg;
    assign upper_digits_word = upper_digits_word_reg;
    assign lower_digits_word = lower_digits_word_reg;

endmodule

// ===== hw/rtl/ssvf_checker.sv =====
module ssvf_checker
    import ssvf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input logic [WORD_W-1:0]   upper_digits_word,
    input logic [WORD_W-1:0]   lower_digits_word
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(upper_digits_word) && $stable(lower_digits_word))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !upper_digits_word[7] && !lower_digits_word[7])
        else $error("decimal point lit");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> lower_digits_word[14:8] != SEG_BLANK && lower_digits_word[6:0] != SEG_BLANK
            && lower_digits_word[14:8] != SEG_DASH && lower_digits_word[6:0] != SEG_DASH
            && upper_digits_word[6:0] != SEG_BLANK && upper_digits_word[6:0] != SEG_DASH)
        else $error("low digits not a numeral");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> upper_digits_word[14:8] == 7'h00 || upper_digits_word[14:8] == 7'h40
            || upper_digits_word[14:8] == 7'h3F || upper_digits_word[14:8] == 7'h06
            || upper_digits_word[14:8] == 7'h5B || upper_digits_word[14:8] == 7'h4F
            || upper_digits_word[14:8] == 7'h66 || upper_digits_word[14:8] == 7'h6D)
        else $error("leading digit pattern out of range");

endmodule

bind seven_segment_view_formatter_unit ssvf_checker u_ssvf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .upper_digits_word (upper_digits_word),
    .lower_digits_word (lower_digits_word)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ssvf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int DAY_SECONDS = 86400;
    localparam int ADC_OFFSET = 2692;
    localparam int SLOPE_NUM = 4225;
    localparam int SLOPE_DEN = 4095;
    localparam seg_t DIGIT_SEGS [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                         7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

    typedef struct {
        kind_t               view;
        logic [31:0]         sample;
        logic [WORD_W-1:0]   upper;
        logic [WORD_W-1:0]   lower;
    } view_words_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [1:0]          kind = '0;
    logic [31:0]         value = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [WORD_W-1:0]   upper_digits_word;
    logic [WORD_W-1:0]   lower_digits_word;

    view_words_t pending_words[$];
    int send_idle = 1;
    int recv_idle = 1;
    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int item_stalls = 0;
    int negative_temps = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    seven_segment_view_formatter_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .kind              (kind),
        .value             (value),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .upper_digits_word (upper_digits_word),
        .lower_digits_word (lower_digits_word)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic view_words_t format_view(input kind_t k, input logic [31:0] v);
        view_words_t w;
        int unsigned tod;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        longint temp;
        seg_t s0;
        seg_t s1;
        seg_t s2;
        seg_t s3;
        w.view = k;
        w.sample = v;
        case (k)
            KIND_MIN_SEC, KIND_HOUR_MIN:
            begin
                tod = v % DAY_SECONDS;
                hh = tod / 3600;
                mm = (tod % 3600) / 60;
                ss = tod % 60;
                lo = (k == KIND_MIN_SEC) ? ss : mm;
                hi = (k == KIND_MIN_SEC) ? mm : hh;
                s0 = DIGIT_SEGS[lo % 10];
                s1 = DIGIT_SEGS[(lo / 10) % 10];
                s2 = DIGIT_SEGS[hi % 10];
                s3 = DIGIT_SEGS[(hi / 10) % 10];
            end
            KIND_VOLTAGE:
            begin
                mag = v[11:0];
                s0 = DIGIT_SEGS[mag % 10];
                s1 = DIGIT_SEGS[(mag / 10) % 10];
                s2 = DIGIT_SEGS[(mag / 100) % 10];
                s3 = DIGIT_SEGS[(mag / 1000) % 10];
            end
            default:
            begin
                temp = ((longint'(v[11:0]) - ADC_OFFSET) * SLOPE_NUM) / SLOPE_DEN;
                mag = (temp < 0) ? -temp : temp;
                s0 = DIGIT_SEGS[mag % 10];
                s1 = DIGIT_SEGS[(mag / 10) % 10];
                s2 = DIGIT_SEGS[(mag / 100) % 10];
                s3 = (temp < 0) ? SEG_DASH : SEG_BLANK;
            end
        endcase
        w.upper = {s3, 1'b0, s2};
        w.lower = {s1, 1'b0, s0};
        return w;
    endfunction

    function automatic int pick_gap(input int level);
        int r;
        r = $urandom_range(0, 99);
        if (level == 0)
            return 0;
        if (level == 1)
        begin
            if (r < 55) return 0;
            if (r < 85) return $urandom_range(1, 3);
            if (r < 97) return $urandom_range(4, 12);
            return $urandom_range(20, 60);
        end
        if (r < 30) return 0;
        if (r < 60) return $urandom_range(1, 4);
        if (r < 85) return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] pick_value(input kind_t k);
        logic [31:0] v;
        int r;
        r = $urandom_range(0, 9);
        if (k == KIND_MIN_SEC || k == KIND_HOUR_MIN)
        begin
            case (r)
                0, 1, 2: v = $urandom;
                3, 4, 5: v = $urandom_range(0, DAY_SECONDS - 1);
                6, 7:    v = 32'(DAY_SECONDS) * $urandom_range(0, 49710)
                             + $urandom_range(0, 2) - 1;
                8:       v = $urandom_range(0, 23) * 3600 + $urandom_range(0, 59) * 60
                             + ($urandom_range(0, 1) ? 59 : 0);
                default: v = 32'hFFFF_FFFF - $urandom_range(0, 200000);
            endcase
        end
        else
        begin
            v = $urandom & 32'hFFFF_F000;
            case (r)
                0, 1, 2, 3, 4, 5: v[11:0] = $urandom_range(0, 4095);
                6, 7:    v[11:0] = ADC_OFFSET - 40 + $urandom_range(0, 80);
                8:       v[11:0] = $urandom_range(0, 1) ? $urandom_range(0, 20)
                                                        : $urandom_range(4075, 4095);
                default: v[11:0] = $urandom_range(0, 4) * 1000 + $urandom_range(0, 2) - 1;
            endcase
        end
        return v;
    endfunction

    task automatic send_item(input kind_t k, input logic [31:0] v);
        int gap;
        view_words_t w;
        gap = pick_gap(send_idle);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        value <= v;
        do
            @(posedge clk);
        while (!item_ready);
        w = format_view(k, v);
        pending_words.push_back(w);
        kind_count[k]++;
        if (k == KIND_TEMP && w.upper[14:8] == SEG_DASH)
            negative_temps++;
    endtask

    task automatic test_time_views();
        send_item(KIND_MIN_SEC, 32'd0);
        send_item(KIND_MIN_SEC, 32'd59);
        send_item(KIND_MIN_SEC, 32'd3599);
        send_item(KIND_MIN_SEC, 32'd86399);
        send_item(KIND_MIN_SEC, 32'd86400);
        send_item(KIND_MIN_SEC, 32'd86401);
        send_item(KIND_MIN_SEC, 32'hFFFF_FFFF);
        send_item(KIND_MIN_SEC, 32'd43261);
        send_item(KIND_HOUR_MIN, 32'd0);
        send_item(KIND_HOUR_MIN, 32'd86399);
        send_item(KIND_HOUR_MIN, 32'd86400);
        send_item(KIND_HOUR_MIN, 32'hFFFF_FFFF);
        send_item(KIND_HOUR_MIN, 32'd86340);
    endtask

    task automatic test_voltage_view();
        send_item(KIND_VOLTAGE, 32'd0);
        send_item(KIND_VOLTAGE, 32'd4095);
        send_item(KIND_VOLTAGE, 32'd1000);
        send_item(KIND_VOLTAGE, 32'hFFFF_F3E7);
        send_item(KIND_VOLTAGE, 32'd9);
    endtask

    task automatic test_temperature_view();
        send_item(KIND_TEMP, 32'd0);
        send_item(KIND_TEMP, 32'hFFFF_FFFF);
        send_item(KIND_TEMP, 32'd2692);
        send_item(KIND_TEMP, 32'd2691);
        send_item(KIND_TEMP, 32'd2693);
        send_item(KIND_TEMP, 32'hABCD_EA82);
    endtask

    task automatic run_random(input int count);
        kind_t k;
        repeat (count)
        begin
            k = kind_t'($urandom_range(0, 3));
            send_item(k, pick_value(k));
        end
    endtask

    task automatic test_back_to_back();
        send_idle = 0;
        recv_idle = 0;
        run_random(200);
    endtask

    task automatic test_random_gaps();
        send_idle = 1;
        recv_idle = 1;
        run_random(250);
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 2;
        run_random(175);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (recv_idle != 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap(recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        view_words_t w;
        if (rst_n && item_valid && !item_ready)
            item_stalls++;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result upper=%h lower=%h",
                             upper_digits_word, lower_digits_word);
            end
            else
            begin
                w = pending_words.pop_front();
                if (upper_digits_word !== w.upper || lower_digits_word !== w.lower)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %s value=%h: upper exp %h got %h, lower exp %h got %h",
                                 w.view.name(), w.sample, w.upper, upper_digits_word,
                                 w.lower, lower_digits_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_time_views();
        test_voltage_view();
        test_temperature_view();
        test_back_to_back();
        test_random_gaps();
        test_backpressure();
        item_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            mismatches++;
        $display("covered %0d results: %0d min:sec, %0d hour:min, %0d voltage, %0d temperature",
                 results_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("%0d negative temperatures, %0d cycles with item_ready held low, %0d mismatches",
                 negative_temps, item_stalls, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ssvf_pkg.sv
hw/rtl/ssvf_seg_pack.sv
hw/rtl/seven_segment_view_formatter_unit.sv
hw/rtl/ssvf_checker.sv
test/tb.sv
